FILE: rtl/u8ws_pkg.sv
`default_nettype none

package u8ws_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD1_CODE = 8'h00;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [2:0] MAX_SEQ_LEN = 3'd4;

    localparam int MAX_WORD_POINTS = 256;

    localparam int             CFG_AW             = 3;
    localparam logic [CFG_AW-1:0] REG_SCREEN_COLUMNS = 3'd0;
    localparam logic [9:0]     SCREEN_COLUMNS_RST = 10'd80;

    localparam int OUT_DEPTH = 4;
    localparam int TDATA_W   = 80;
    localparam int TUSER_W   = 2;

    typedef struct packed {
        logic [10:0] word_bytes;
        logic [8:0]  code_points;
        logic [9:0]  middle_offset;
        logic [2:0]  middle_length;
        logic [8:0]  pad_columns;
        logic        extra_pause;
        logic [31:0] end_offset;
        logic        too_long;
        logic        last_in_run;
    } t_word_rec;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & LEAD1_MASK) == LEAD1_CODE) len = 3'd1;
        else if ((b & LEAD2_MASK) == LEAD2_CODE) len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
        else len = 3'd1;
        return len;
    endfunction

    function automatic logic is_sep(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
    endfunction

    function automatic logic is_stop(input logic [7:0] b);
        return (b == CH_DOT) || (b == CH_BANG) || (b == CH_QUEST);
    endfunction

    function automatic logic [2:0] clip_len(input logic [2:0] len, input logic [2:0] room);
        return (len > room) ? room : len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_word_segmenter.sv
`default_nettype none

// channel    dir   handshake                  payload
// s_axis     in    tvalid/tready              tdata: text_byte; tlast: end_of_text
// m_axis     out   tvalid/tready              tdata/tuser: word result; tlast: last_in_run
// apb        in    psel/penable/pwrite/pready screen_columns at byte address 0
//
// One text byte per cycle while tready is high; counts update in the cycle a byte is taken.
// A result is registered at the scan output and then queued after the byte that closes its
// word; its middle length comes from the lead length store read for its last counted lead.
// A small result queue decouples the sides; s_axis_tready drops only while queued and
// staged results leave room for fewer than two more.
// Synchronous active-low reset clears control state; the lead length store is not cleared.

module utf8_word_segmenter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] text_byte
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [10:0] word_bytes, [19:11] code_points, [29:20] middle_offset,
    // [32:30] middle_length, [41:33] pad_columns, [73:42] end_offset
    output logic [u8ws_pkg::TDATA_W-1:0]       m_axis_tdata,
    output logic [u8ws_pkg::TUSER_W-1:0]       m_axis_tuser,   // [0] extra_pause, [1] too_long
    output logic                               m_axis_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u8ws_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = $clog2(u8ws_pkg::MAX_WORD_POINTS);
    localparam int CW = $clog2(u8ws_pkg::OUT_DEPTH + 1);

    logic [9:0]          r_screen_columns;
    logic                take;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [2:0]          mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [2:0]          mem_rdata;
    logic [1:0]          push_cnt;
    u8ws_pkg::t_word_rec push_a;
    u8ws_pkg::t_word_rec push_b;
    u8ws_pkg::t_word_rec out_rec;
    logic [CW-1:0]       fifo_cnt;

    assign pready = 1'b1;
    assign prdata = (paddr == u8ws_pkg::REG_SCREEN_COLUMNS) ? 32'(r_screen_columns) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_columns <= u8ws_pkg::SCREEN_COLUMNS_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr == u8ws_pkg::REG_SCREEN_COLUMNS)) begin
            r_screen_columns <= pwdata[9:0];
        end
    end

    assign s_axis_tready = (fifo_cnt + CW'(push_cnt)) <= CW'(u8ws_pkg::OUT_DEPTH - 2);
    assign take          = s_axis_tvalid && s_axis_tready;

    u8ws_lead_mem #(
        .DEPTH(u8ws_pkg::MAX_WORD_POINTS)
    ) u_lead_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    u8ws_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (s_axis_tdata),
        .i_eot      (s_axis_tlast),
        .i_half_cols(r_screen_columns[9:1]),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .o_mem_re   (mem_re),
        .o_mem_raddr(mem_raddr),
        .i_mem_rdata(mem_rdata),
        .o_push_cnt (push_cnt),
        .o_push_a   (push_a),
        .o_push_b   (push_b)
    );

    u8ws_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(push_cnt),
        .i_push_a  (push_a),
        .i_push_b  (push_b),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rec     (out_rec),
        .o_cnt     (fifo_cnt)
    );

    assign m_axis_tdata = {6'd0, out_rec.end_offset, out_rec.pad_columns,
                           out_rec.middle_length, out_rec.middle_offset,
                           out_rec.code_points, out_rec.word_bytes};
    assign m_axis_tuser = {out_rec.too_long, out_rec.extra_pause};
    assign m_axis_tlast = out_rec.last_in_run;

endmodule

`default_nettype wire

FILE: rtl/u8ws_lead_mem.sv
`default_nettype none

module u8ws_lead_mem #(
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [2:0]               i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [2:0]               o_rdata
);

    logic [2:0] r_mem [DEPTH];
    logic [2:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/u8ws_scan.sv
`default_nettype none

module u8ws_scan (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_take,
    input  wire logic [7:0]                                   i_byte,
    input  wire logic                                         i_eot,
    input  wire logic [8:0]                                   i_half_cols,
    output logic                                              o_mem_we,
    output logic      [$clog2(u8ws_pkg::MAX_WORD_POINTS)-1:0] o_mem_waddr,
    output logic      [2:0]                                   o_mem_wdata,
    output logic                                              o_mem_re,
    output logic      [$clog2(u8ws_pkg::MAX_WORD_POINTS)-1:0] o_mem_raddr,
    input  wire logic [2:0]                                   i_mem_rdata,
    output logic      [1:0]                                   o_push_cnt,
    output u8ws_pkg::t_word_rec                               o_push_a,
    output u8ws_pkg::t_word_rec                               o_push_b
);

    localparam int AW = $clog2(u8ws_pkg::MAX_WORD_POINTS);
    localparam int PW = $clog2(u8ws_pkg::MAX_WORD_POINTS + 1);
    localparam int BW = $clog2(4 * u8ws_pkg::MAX_WORD_POINTS + 1);
    localparam int MW = (PW > 10) ? PW : 10;
    localparam logic [PW-1:0] MAX_PTS   = PW'(u8ws_pkg::MAX_WORD_POINTS);
    localparam logic [BW-1:0] MAX_BYTES = BW'(4 * u8ws_pkg::MAX_WORD_POINTS);

    logic          r_in_word, n_in_word;
    logic          r_pending, n_pending;
    logic [31:0]   r_byte_cnt, n_byte_cnt;
    logic [BW-1:0] r_wbc, n_wbc;
    logic [PW-1:0] r_pc, n_pc;
    logic [BW-1:0] r_acc, n_acc;
    logic [1:0]    r_cd, n_cd;
    logic          r_ends, n_ends;
    logic [1:0]    r_nl_run, n_nl_run;
    logic [31:0]   r_end_off, n_end_off;
    logic          r_ovf, n_ovf;
    logic          r_mid_sel, n_mid_sel;
    logic [2:0]    r_mid_fwd, n_mid_fwd;

    logic                r_b_v0, r_b_v1;
    u8ws_pkg::t_word_rec r_b_rec0, r_b_rec1;
    logic [2:0]          r_b_room1;

    logic                sep;
    logic [2:0]          len;
    logic [2:0]          mid_eff;
    logic [31:0]         cnt_inc;
    logic                start;
    logic                emit0;
    logic                emit1;
    logic [BW-1:0]       base_wbc;
    logic [PW-1:0]       base_pc;
    logic [BW-1:0]       base_acc;
    logic [1:0]          base_cd;
    logic [1:0]          base_nl;
    logic                base_ovf;
    logic [PW-1:0]       pc_inc;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    u8ws_pkg::t_word_rec rec0;
    u8ws_pkg::t_word_rec rec1;
    logic [2:0]          room1;
    u8ws_pkg::t_word_rec fin1;

    function automatic u8ws_pkg::t_word_rec make_rec(
        input logic [BW-1:0] wbc,
        input logic [PW-1:0] pts,
        input logic [BW-1:0] acc,
        input logic          extra,
        input logic [31:0]   eoff,
        input logic          ovf,
        input logic          last,
        input logic [8:0]    half
    );
        u8ws_pkg::t_word_rec rec;
        logic [MW-1:0]       mid;
        mid               = MW'(pts >> 1);
        rec.word_bytes    = 11'(wbc);
        rec.code_points   = 9'(pts);
        rec.middle_offset = 10'(acc);
        rec.middle_length = 3'd0;
        rec.pad_columns   = (MW'(half) > mid) ? 9'(MW'(half) - mid) : 9'd0;
        rec.extra_pause   = extra;
        rec.end_offset    = eoff;
        rec.too_long      = ovf;
        rec.last_in_run   = last;
        return rec;
    endfunction

    function automatic logic [2:0] room_clip(input logic [BW-1:0] wbc, input logic [BW-1:0] acc);
        logic [BW-1:0] diff;
        diff = (wbc > acc) ? wbc - acc : '0;
        return (diff > BW'(u8ws_pkg::MAX_SEQ_LEN)) ? u8ws_pkg::MAX_SEQ_LEN : 3'(diff);
    endfunction

    always_comb begin
        sep      = u8ws_pkg::is_sep(i_byte);
        len      = u8ws_pkg::lead_len(i_byte);
        mid_eff  = r_mid_sel ? i_mem_rdata : r_mid_fwd;
        cnt_inc  = r_byte_cnt + 32'd1;
        start    = !sep && !r_in_word;
        emit0    = start && r_pending;

        base_wbc = start ? '0 : r_wbc;
        base_pc  = start ? '0 : r_pc;
        base_acc = start ? '0 : r_acc;
        base_cd  = start ? 2'd0 : r_cd;
        base_nl  = start ? 2'd0 : r_nl_run;
        base_ovf = start ? 1'b0 : r_ovf;
        pc_inc   = base_pc + PW'(1);

        n_in_word  = r_in_word;
        n_pending  = r_pending;
        n_byte_cnt = r_byte_cnt;
        n_wbc      = r_wbc;
        n_pc       = r_pc;
        n_acc      = r_acc;
        n_cd       = r_cd;
        n_ends     = r_ends;
        n_nl_run   = r_nl_run;
        n_end_off  = r_end_off;
        n_ovf      = r_ovf;
        n_mid_sel  = r_mid_sel;
        n_mid_fwd  = r_mid_fwd;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = AW'(base_pc);
        mem_raddr = AW'(pc_inc >> 1);

        if (i_take) begin
            n_byte_cnt = cnt_inc;
            if (sep) begin
                if (r_in_word) begin
                    n_in_word = 1'b0;
                    n_pending = 1'b1;
                end
                if ((r_in_word || r_pending) && (i_byte == u8ws_pkg::CH_NL)
                    && !r_nl_run[1]) begin
                    n_nl_run = r_nl_run + 2'd1;
                end
            end else begin
                n_in_word = 1'b1;
                n_pending = 1'b0;
                n_wbc     = (base_wbc < MAX_BYTES) ? base_wbc + BW'(1) : base_wbc;
                n_pc      = base_pc;
                n_acc     = base_acc;
                n_nl_run  = base_nl;
                n_ovf     = base_ovf;
                if (base_cd == 2'd0) begin
                    if (base_pc < MAX_PTS) begin
                        n_pc   = pc_inc;
                        mem_we = 1'b1;
                        mem_re = 1'b1;
                        if (!pc_inc[0]) begin
                            n_acc = base_acc + BW'(mid_eff);
                        end
                        // bypass the store when the new middle is the entry written now
                        n_mid_sel = (mem_raddr != mem_waddr);
                        n_mid_fwd = len;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_cd = 2'(len - 3'd1);
                end else begin
                    n_cd = base_cd - 2'd1;
                end
                n_ends    = u8ws_pkg::is_stop(i_byte);
                n_end_off = cnt_inc;
            end
        end

        rec0 = make_rec(r_wbc, r_pc, r_acc, r_ends || r_nl_run[1], r_end_off, r_ovf,
                        !i_eot, i_half_cols);
        rec0.middle_length = u8ws_pkg::clip_len(mid_eff, room_clip(r_wbc, r_acc));
        rec1  = make_rec(n_wbc, n_pc, n_acc, n_ends || n_nl_run[1], n_end_off, n_ovf,
                         1'b1, i_half_cols);
        room1 = room_clip(n_wbc, n_acc);
        emit1 = i_eot && (n_in_word || n_pending);

        if (i_take && i_eot) begin
            n_in_word  = 1'b0;
            n_pending  = 1'b0;
            n_byte_cnt = 32'd0;
            n_wbc      = '0;
            n_pc       = '0;
            n_acc      = '0;
            n_cd       = 2'd0;
            n_ends     = 1'b0;
            n_nl_run   = 2'd0;
            n_end_off  = 32'd0;
            n_ovf      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word  <= 1'b0;
            r_pending  <= 1'b0;
            r_byte_cnt <= 32'd0;
            r_wbc      <= '0;
            r_pc       <= '0;
            r_acc      <= '0;
            r_cd       <= 2'd0;
            r_ends     <= 1'b0;
            r_nl_run   <= 2'd0;
            r_end_off  <= 32'd0;
            r_ovf      <= 1'b0;
            r_mid_sel  <= 1'b0;
            r_mid_fwd  <= 3'd0;
            r_b_v0     <= 1'b0;
            r_b_v1     <= 1'b0;
        end else begin
            r_in_word  <= n_in_word;
            r_pending  <= n_pending;
            r_byte_cnt <= n_byte_cnt;
            r_wbc      <= n_wbc;
            r_pc       <= n_pc;
            r_acc      <= n_acc;
            r_cd       <= n_cd;
            r_ends     <= n_ends;
            r_nl_run   <= n_nl_run;
            r_end_off  <= n_end_off;
            r_ovf      <= n_ovf;
            r_mid_sel  <= n_mid_sel;
            r_mid_fwd  <= n_mid_fwd;
            r_b_v0     <= i_take && emit0;
            r_b_v1     <= i_take && emit1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_rec0  <= rec0;
        r_b_rec1  <= rec1;
        r_b_room1 <= room1;
    end

    // a word closed by end of text gets its middle length from the store output after registering
    always_comb begin
        fin1               = r_b_rec1;
        fin1.middle_length = u8ws_pkg::clip_len(mid_eff, r_b_room1);
    end

    assign o_mem_we    = mem_we;
    assign o_mem_waddr = mem_waddr;
    assign o_mem_wdata = len;
    assign o_mem_re    = mem_re;
    assign o_mem_raddr = mem_raddr;
    assign o_push_cnt  = {1'b0, r_b_v0} + {1'b0, r_b_v1};
    assign o_push_a    = r_b_v0 ? r_b_rec0 : fin1;
    assign o_push_b    = fin1;

`ifndef ASSERT_OFF
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_eot |=> (r_byte_cnt == 32'd0) && !r_in_word && !r_pending)
        else $error("stream state not cleared after end of text");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v0 && r_b_v1 |-> !r_b_rec0.last_in_run && r_b_rec1.last_in_run)
        else $error("two results from one request out of order");

    a_bytes_cover_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wbc >= BW'(r_pc))
        else $error("code point count exceeds byte count");

    a_points_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= MAX_PTS)
        else $error("code point count past store depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/u8ws_out_fifo.sv
`default_nettype none

module u8ws_out_fifo (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic [1:0]                               i_push_cnt,
    input  wire u8ws_pkg::t_word_rec                      i_push_a,
    input  wire u8ws_pkg::t_word_rec                      i_push_b,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output u8ws_pkg::t_word_rec                           o_rec,
    output logic [$clog2(u8ws_pkg::OUT_DEPTH + 1)-1:0]    o_cnt
);

    localparam int PTRW = $clog2(u8ws_pkg::OUT_DEPTH);
    localparam int CW   = $clog2(u8ws_pkg::OUT_DEPTH + 1);

    u8ws_pkg::t_word_rec r_mem [u8ws_pkg::OUT_DEPTH];
    logic [PTRW-1:0]     r_wp;
    logic [PTRW-1:0]     r_rp;
    logic [CW-1:0]       r_cnt;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_rec   = r_mem[r_rp];
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTRW'(i_push_cnt);
            r_rp  <= r_rp + PTRW'(pop);
            r_cnt <= r_cnt + CW'(i_push_cnt) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_push_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + PTRW'(1)] <= i_push_b;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt + CW'(i_push_cnt)) <= CW'(u8ws_pkg::OUT_DEPTH))
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_utf8_word_segmenter.sv
`timescale 1ns / 100ps

module tb_utf8_word_segmenter;

    localparam int MAX_POINTS  = u8ws_pkg::MAX_WORD_POINTS;
    localparam int MAX_BYTES   = 4 * MAX_POINTS;
    localparam int CYCLE_LIMIT = 60000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = 8'h20;
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [u8ws_pkg::TDATA_W-1:0] m_axis_tdata;
    logic [u8ws_pkg::TUSER_W-1:0] m_axis_tuser;
    logic                         m_axis_tlast;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [u8ws_pkg::CFG_AW-1:0]  paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    utf8_word_segmenter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // segmenter state as predicted
    logic [9:0]  seg_cols;
    logic [2:0]  lead_lens [0:MAX_POINTS-1];
    logic        seg_in_word;
    logic        seg_pending;
    logic [31:0] seg_byte_cnt;
    logic [10:0] seg_word_bytes;
    logic [8:0]  seg_points;
    logic [9:0]  seg_mid_off;
    logic [1:0]  seg_skip;
    logic        seg_stop;
    logic [1:0]  seg_nl_run;
    logic [31:0] seg_end_off;
    logic        seg_overflow;

    u8ws_pkg::t_word_rec expected_words [$];
    logic [8:0]          text_q [$];

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int n_errors = 0;
    int n_cycles = 0;

    function automatic logic [2:0] utf8_seq_len(input logic [7:0] b);
        logic [2:0] len;
        casez (b)
            8'b0???????: len = 3'd1;
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            default:     len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic void reset_text_state();
        seg_in_word    = 1'b0;
        seg_pending    = 1'b0;
        seg_byte_cnt   = '0;
        seg_word_bytes = '0;
        seg_points     = '0;
        seg_mid_off    = '0;
        seg_skip       = '0;
        seg_stop       = 1'b0;
        seg_nl_run     = '0;
        seg_end_off    = '0;
        seg_overflow   = 1'b0;
    endfunction

    function automatic u8ws_pkg::t_word_rec form_word_record(input logic last);
        u8ws_pkg::t_word_rec r;
        int n;
        int mid;
        int ml;
        int room;
        int half;
        n   = int'(seg_points);
        mid = n / 2;
        ml  = 0;
        if (n > 0 && mid < MAX_POINTS) ml = int'(lead_lens[8'(mid)]);
        room = (seg_word_bytes > 11'(seg_mid_off)) ?
               int'(seg_word_bytes) - int'(seg_mid_off) : 0;
        if (ml > room) ml = room;
        half = int'(seg_cols) / 2;
        r.word_bytes    = seg_word_bytes;
        r.code_points   = seg_points;
        r.middle_offset = seg_mid_off;
        r.middle_length = 3'(ml);
        r.pad_columns   = 9'((half > mid) ? half - mid : 0);
        r.extra_pause   = seg_stop || (seg_nl_run >= 2'd2);
        r.end_offset    = seg_end_off;
        r.too_long      = seg_overflow;
        r.last_in_run   = last;
        return r;
    endfunction

    function automatic void predict_text_byte(input logic [7:0] b, input logic eot);
        logic       sep;
        logic [2:0] len;
        sep = (b == u8ws_pkg::CH_SPACE) || (b == u8ws_pkg::CH_TAB) || (b == u8ws_pkg::CH_NL);
        seg_byte_cnt = seg_byte_cnt + 32'd1;
        if (sep) begin
            if (seg_in_word) begin
                seg_in_word = 1'b0;
                seg_pending = 1'b1;
            end
            if (seg_pending && b == u8ws_pkg::CH_NL && seg_nl_run < 2'd2)
                seg_nl_run = seg_nl_run + 2'd1;
        end else begin
            if (!seg_in_word) begin
                if (seg_pending) expected_words.push_back(form_word_record(!eot));
                seg_in_word    = 1'b1;
                seg_pending    = 1'b0;
                seg_word_bytes = '0;
                seg_points     = '0;
                seg_mid_off    = '0;
                seg_skip       = '0;
                seg_nl_run     = '0;
                seg_overflow   = 1'b0;
            end
            if (seg_word_bytes < 11'(MAX_BYTES)) seg_word_bytes = seg_word_bytes + 11'd1;
            if (seg_skip == 2'd0) begin
                len = utf8_seq_len(b);
                if (seg_points < 9'(MAX_POINTS)) begin
                    lead_lens[seg_points[7:0]] = len;
                    seg_points = seg_points + 9'd1;
                    if (!seg_points[0])
                        seg_mid_off = seg_mid_off + 10'(lead_lens[seg_points[8:1] - 8'd1]);
                end else begin
                    seg_overflow = 1'b1;
                end
                seg_skip = 2'(len - 3'd1);
            end else begin
                seg_skip = seg_skip - 2'd1;
            end
            seg_stop    = (b == u8ws_pkg::CH_DOT) || (b == u8ws_pkg::CH_BANG) ||
                          (b == u8ws_pkg::CH_QUEST);
            seg_end_off = seg_byte_cnt;
        end
        if (eot) begin
            if (seg_in_word || seg_pending) expected_words.push_back(form_word_record(1'b1));
            reset_text_state();
        end
    endfunction

    function automatic string fmt_word(input u8ws_pkg::t_word_rec w);
        return {$sformatf("bytes=%0d pts=%0d mid_off=%0d mid_len=%0d pad=%0d ",
                          w.word_bytes, w.code_points, w.middle_offset, w.middle_length,
                          w.pad_columns),
                $sformatf("pause=%0b end=%0d long=%0b last=%0b",
                          w.extra_pause, w.end_offset, w.too_long, w.last_in_run)};
    endfunction

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("%0t ERROR %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_utf8_word_segmenter: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(negedge i_clk) begin : check_words
        u8ws_pkg::t_word_rec got;
        u8ws_pkg::t_word_rec want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.word_bytes    = m_axis_tdata[10:0];
            got.code_points   = m_axis_tdata[19:11];
            got.middle_offset = m_axis_tdata[29:20];
            got.middle_length = m_axis_tdata[32:30];
            got.pad_columns   = m_axis_tdata[41:33];
            got.end_offset    = m_axis_tdata[73:42];
            got.extra_pause   = m_axis_tuser[0];
            got.too_long      = m_axis_tuser[1];
            got.last_in_run   = m_axis_tlast;
            if (expected_words.size() == 0) begin
                report_error($sformatf("unexpected word: %s", fmt_word(got)));
            end else begin
                want = expected_words.pop_front();
                if (got !== want)
                    report_error($sformatf("word mismatch\n  exp %s\n  got %s",
                                           fmt_word(want), fmt_word(got)));
            end
        end
    end

    // request one text byte; returns at the edge that takes it
    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        logic taken;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            if (taken) predict_text_byte(b, eot);
            @(posedge i_clk);
        end
    endtask

    task automatic send_queued_text();
        logic [8:0] item;
        while (text_q.size() != 0) begin
            item = text_q.pop_front();
            send_text_byte(item[7:0], item[8]);
        end
    endtask

    // drop valid, drain all expected words, then allow the pipeline to empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_columns(input logic [9:0] cols);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= u8ws_pkg::REG_SCREEN_COLUMNS;
        pwdata  <= {22'd0, cols};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        seg_cols = cols;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        if (prdata[9:0] !== cols)
            report_error($sformatf("screen_columns read exp %0d got %0d", cols, prdata[9:0]));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void push_byte(input logic [7:0] b);
        text_q.push_back({1'b0, b});
    endfunction

    function automatic void mark_end();
        if (text_q.size() != 0) text_q[text_q.size() - 1][8] = 1'b1;
    endfunction

    function automatic void push_code_point(input bit may_truncate);
        int         kind;
        int         len;
        int         keep;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        len  = 1;
        if (kind < 45) begin
            lead = 8'($urandom_range(8'h21, 8'h7E));
        end else if (kind < 55) begin
            case ($urandom_range(0, 2))
                0:       lead = u8ws_pkg::CH_DOT;
                1:       lead = u8ws_pkg::CH_BANG;
                default: lead = u8ws_pkg::CH_QUEST;
            endcase
        end else if (kind < 70) begin
            lead = 8'(8'hC0 + $urandom_range(0, 31));
            len  = 2;
        end else if (kind < 80) begin
            lead = 8'(8'hE0 + $urandom_range(0, 15));
            len  = 3;
        end else if (kind < 88) begin
            lead = 8'(8'hF0 + $urandom_range(0, 7));
            len  = 4;
        end else if (kind < 94) begin
            lead = 8'($urandom_range(8'h80, 8'hBF));
        end else begin
            lead = 8'($urandom_range(8'hF8, 8'hFF));
        end
        push_byte(lead);
        keep = len - 1;
        if (may_truncate && len > 1 && $urandom_range(0, 3) == 0) keep = $urandom_range(0, len - 2);
        repeat (keep) push_byte(8'(8'h80 + $urandom_range(0, 63)));
    endfunction

    function automatic void push_word(input int npts);
        for (int i = 0; i < npts; i++) push_code_point(i == npts - 1);
    endfunction

    function automatic void push_gap();
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
                0:       push_byte(u8ws_pkg::CH_SPACE);
                1:       push_byte(u8ws_pkg::CH_TAB);
                default: push_byte(u8ws_pkg::CH_NL);
            endcase
        end
    endfunction

    task automatic random_text(input int nbytes);
        int r;
        while (text_q.size() < nbytes) begin
            r = $urandom_range(0, 99);
            if (r < 8) repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(1, 255)));
            else push_word((r < 12) ? $urandom_range(10, 30) : $urandom_range(1, 8));
            if ($urandom_range(0, 9) != 0) push_gap();
            if ($urandom_range(0, 24) == 0) mark_end();
        end
        mark_end();
        send_queued_text();
    endtask

    task automatic test_directed();
        // a single 01h byte as a whole text
        push_byte(8'h01);
        mark_end();
        // sentence end, paragraph break, and two words out of one final byte
        push_byte("a");
        push_byte("b");
        push_byte(u8ws_pkg::CH_DOT);
        push_byte(u8ws_pkg::CH_NL);
        push_byte(u8ws_pkg::CH_NL);
        push_byte("x");
        mark_end();
        // stray bytes, a full 4-byte sequence, a separator cutting a sequence
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(u8ws_pkg::CH_SPACE);
        push_byte(8'hF0);
        push_byte(8'h9F);
        push_byte(8'h98);
        push_byte(8'h80);
        push_byte(u8ws_pkg::CH_QUEST);
        push_byte(u8ws_pkg::CH_TAB);
        push_byte(8'hE2);
        push_byte(u8ws_pkg::CH_SPACE);
        push_byte(8'hC3);
        push_byte(8'hA9);
        push_byte(u8ws_pkg::CH_BANG);
        push_byte(u8ws_pkg::CH_SPACE);
        mark_end();
        // text with no word
        push_byte(u8ws_pkg::CH_SPACE);
        mark_end();
        send_queued_text();
        settle();
    endtask

    task automatic test_long_words();
        // one word past the code point store, then a paragraph break
        repeat (MAX_POINTS + 3) push_byte(8'($urandom_range(8'h21, 8'h7E)));
        push_byte(u8ws_pkg::CH_NL);
        push_byte(u8ws_pkg::CH_NL);
        mark_end();
        send_queued_text();
        settle();
    endtask

    task automatic test_screen_columns();
        write_columns(10'd1);
        random_text(40);
        settle();
        write_columns(10'd1023);
        random_text(40);
        settle();
    endtask

    task automatic test_random_stream(input int src_pct, input int sink_pct, input int nbytes);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        write_columns(10'($urandom_range(1, 1023)));
        random_text(nbytes);
        settle();
    endtask

    initial begin
        reset_text_state();
        seg_cols      = u8ws_pkg::SCREEN_COLUMNS_RST;
        src_idle_pct  = 21;
        sink_idle_pct = 72;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_words();
        test_screen_columns();
        test_random_stream(21, 72, 160);
        test_random_stream(72, 21, 160);
        test_random_stream(0, 0, 160);

        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_utf8_word_segmenter: PASS");
        end else begin
            $display("tb_utf8_word_segmenter: FAIL");
        end
        $finish;
    end

endmodule
